/* design/htdi_pkg.sv */
// Package for the hourly table date interpolator: payload structs, codes,
// controller states and the command/status structs between ctrl and datapath.
package htdi_pkg;

  localparam int TableDepth = 16384;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_INTERP = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  rec_month;
    logic [4:0]  rec_day;
    logic [12:0] rec_hour;
    logic [14:0] beam_irradiance;
    logic [14:0] sky_irradiance;
    logic [13:0] entry_index;
    logic [16:0] blend_fraction;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [12:0] out_hour;
    logic [14:0] out_beam;
    logic [14:0] out_sky;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [12:0] hour;
    logic [14:0] beam;
    logic [14:0] sky;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_WAIT_A, S_RD_B, S_WAIT_B, S_CHECK,
    S_DIV, S_BLEND, S_MUL, S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request
    logic load;      // write record, bump count
    logic rd_a;      // read entry at cursor
    logic rd_b;      // read entry after cursor
    logic take_a;    // latch read data as first entry
    logic take_b;    // latch read data as second entry
    logic step;      // advance cursor
    logic div_start;
    logic frac_req;  // fraction from request
    logic mul;       // run blend multiplies
    logic [2:0] err; // status for error result
    logic emit_err;
    logic emit_ok;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_bad;
    logic hit;       // first entry on queried date, pair brackets queried hour
    logic last;      // cursor at last loaded entry
    logic div_done;
  } sts_t;

endpackage

/* design/htdi_div.sv */
// Restoring divider, one quotient bit a cycle: (num << 16) / den, 17-bit quotient.
// Standalone; used by htdi_datapath.
module htdi_div
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [12:0] num_i,
  input  logic [12:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [13:0] rem_q, rem_d;
  logic [28:0] dvd_q, dvd_d;
  logic [12:0] den_q, den_d;
  logic [14:0] trial;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; rem_d = rem_q; dvd_d = dvd_q; den_d = den_q;
    trial = {rem_q, dvd_q[28]} - {2'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 5'd0; rem_d = '0;
      dvd_d = {num_i, 16'b0}; den_d = den_i;
    end else if (busy_q) begin
      if (!trial[14]) rem_d = trial[13:0];
      else rem_d = {rem_q[12:0], dvd_q[28]};
      dvd_d = {dvd_q[27:0], ~trial[14]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd28) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; dvd_q <= dvd_d; den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd28);
  // span >= hour offset, so quotient fits 17 bits
  assign quo_o  = {dvd_q[15:0], ~trial[14]};
endmodule

/* design/htdi_datapath.sv */
// Datapath: record memory, entry count, scan cursor, fraction and blend math.
// Depends on htdi_pkg and htdi_div.
module htdi_datapath
  import htdi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  req_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      done_o,
  output out_word_t result_o
);
  rec_t           mem [TableDepth];
  rec_t           rd_q;
  in_word_t       req_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] cur_q, nxt_idx;
  rec_t           a_q, b_q;
  logic [16:0]    frac_q, quo;
  logic           div_done;
  logic signed [33:0] ph_q, pb_q, ps_q;
  out_word_t      res_q;
  logic           done_q;

  // next index with wrap at loaded count
  assign nxt_idx = ({1'b0, cur_q} + 1'b1 == cnt_q) ? '0 : cur_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[cnt_q[IdxW-1:0]] <= {req_q.rec_month, req_q.rec_day,
      req_q.rec_hour, req_q.beam_irradiance, req_q.sky_irradiance};
    if (cmd_i.rd_a) rd_q <= mem[cur_q];
    else if (cmd_i.rd_b) rd_q <= mem[nxt_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; cur_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit_err | cmd_i.emit_ok;
      if (cmd_i.load) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.capture)
        cur_q <= (req_i.req_type == REQ_INTERP) ? req_i.entry_index[IdxW-1:0] : '0;
      else if (cmd_i.step) cur_q <= cur_q + 1'b1;
    end
  end

  htdi_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .num_i(req_q.rec_hour - a_q.hour), .den_i(b_q.hour - a_q.hour),
    .done_o(div_done), .quo_o(quo)
  );

  function automatic logic signed [33:0] prod(input logic [14:0] s, input logic [14:0] e,
                                             input logic [16:0] f);
    logic signed [16:0] d;
    d = $signed({2'b0, e}) - $signed({2'b0, s});
    return d * $signed({1'b0, f});
  endfunction

  function automatic logic [14:0] rnd(input logic [14:0] s, input logic signed [33:0] p);
    logic signed [33:0] t;
    t = p + 34'sd32768;
    return s + t[30:16]; // arithmetic shift = floor
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.take_a) a_q <= rd_q;
    if (cmd_i.take_b) b_q <= rd_q;
    if (cmd_i.frac_req)
      frac_q <= (req_q.blend_fraction > 17'd65536) ? 17'd65536 : req_q.blend_fraction;
    else if (cmd_i.div_start && b_q.hour == a_q.hour) frac_q <= '0;
    // zero span keeps fraction 0; the divider result is meaningless then
    else if (div_done && b_q.hour != a_q.hour) frac_q <= quo;
    if (cmd_i.mul) begin
      ph_q <= prod({2'b0, a_q.hour}, {2'b0, b_q.hour}, frac_q);
      pb_q <= prod(a_q.beam, b_q.beam, frac_q);
      ps_q <= prod(a_q.sky, b_q.sky, frac_q);
    end
    if (cmd_i.emit_err) res_q <= {cmd_i.err, 52'b0};
    else if (cmd_i.emit_ok) begin
      res_q.status    <= ST_OK;
      res_q.out_month <= a_q.month;
      res_q.out_day   <= a_q.day;
      res_q.out_hour  <= 13'(rnd({2'b0, a_q.hour}, ph_q));
      if (a_q.sky == '0 && b_q.sky == '0) begin
        res_q.out_beam <= '0; res_q.out_sky <= '0;
      end else begin
        res_q.out_beam <= rnd(a_q.beam, pb_q);
        res_q.out_sky  <= rnd(a_q.sky, ps_q);
      end
    end
  end

  assign sts_o.full     = cnt_q[IdxW];
  assign sts_o.empty    = cnt_q == '0;
  assign sts_o.idx_bad  = {1'b0, req_q.entry_index} >= cnt_q;
  assign sts_o.hit      = a_q.month == req_q.rec_month && a_q.day == req_q.rec_day &&
                          a_q.hour <= req_q.rec_hour && b_q.hour >= req_q.rec_hour;
  assign sts_o.last     = {1'b0, cur_q} + 1'b1 == cnt_q;
  assign sts_o.div_done = div_done;
  assign done_o   = done_q;
  assign result_o = res_q;
endmodule

/* design/htdi_ctrl.sv */
// Controller FSM sequencing load, query scan and interpolate.
// Depends on htdi_pkg.
module htdi_ctrl
  import htdi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic [1:0] req_type_i,
  input  sts_t     sts_i,
  output cmd_t     cmd_o,
  output logic     busy_o
);
  state_e state_q, state_d;
  req_e   req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; req_q <= REQ_NONE;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == S_IDLE) req_q <= req_e'(req_type_i);
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.capture = 1'b1; state_d = S_CHECK;
      end
      S_CHECK: begin
        case (req_q)
          REQ_LOAD: begin
            if (sts_i.full) begin cmd_o.emit_err = 1'b1; cmd_o.err = ST_FULL; end
            else begin cmd_o.load = 1'b1; cmd_o.emit_err = 1'b1; cmd_o.err = ST_OK; end
            state_d = S_DONE;
          end
          REQ_QUERY, REQ_INTERP: begin
            if (sts_i.empty) begin
              cmd_o.emit_err = 1'b1; cmd_o.err = ST_EMPTY; state_d = S_DONE;
            end else if (req_q == REQ_INTERP && sts_i.idx_bad) begin
              cmd_o.emit_err = 1'b1; cmd_o.err = ST_RANGE; state_d = S_DONE;
            end else begin
              cmd_o.rd_a = 1'b1; state_d = S_RD_A;
            end
          end
          default: begin
            cmd_o.emit_err = 1'b1; cmd_o.err = ST_OK; state_d = S_DONE;
          end
        endcase
      end
      // read data holds the entry at the cursor here: read in S_CHECK on the
      // first pass, the previous second entry after a step
      S_RD_A: begin
        cmd_o.take_a = 1'b1; cmd_o.rd_b = 1'b1; state_d = S_WAIT_A;
      end
      S_WAIT_A: begin cmd_o.take_b = 1'b1; state_d = S_RD_B; end
      S_RD_B: state_d = S_WAIT_B;
      S_WAIT_B: begin
        if (req_q == REQ_INTERP) begin
          cmd_o.frac_req = 1'b1; state_d = S_BLEND;
        end else if (sts_i.hit) begin
          cmd_o.div_start = 1'b1; state_d = S_DIV;
        end else if (sts_i.last) begin
          cmd_o.emit_err = 1'b1; cmd_o.err = ST_NOTFOUND; state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1; state_d = S_RD_A;
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_BLEND;
      S_BLEND: begin cmd_o.mul = 1'b1; state_d = S_MUL; end
      S_MUL: begin cmd_o.emit_ok = 1'b1; state_d = S_DONE; end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_ok && cmd_o.emit_err)) else $error("double emit");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !sts_i.full) else $error("load into full table");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE) else $error("done not followed by idle");
endmodule

/* design/hourly_table_date_interpolator.sv */
// Hourly irradiance table with date lookup and linear blending.
// Command style: a word is accepted when start is high and busy low.
// One result word per request appears on result_o for one cycle with
// done_o high; the receiver cannot stall it.
// Sequence: load, unknown type and early errors are answered from the check
// state; interpolate reads its two entries, then blends. A date query reads
// two entries per scanned entry (one read port), reports not found after the
// last loaded entry, and on a hit runs the bit-serial divide, then the blend.
// busy covers the whole request and drops the cycle after the result, so the
// next word is taken then.
// Reset clears the entry count and controller; record memory contents are
// not cleared, and only loaded entries are ever read.
// Blend: s + floor(((e-s)*f + 2^15) / 2^16), f in Q1.16. Night (both sky
// values zero) forces beam and sky to zero.
// Depends on htdi_pkg, htdi_ctrl, htdi_datapath, htdi_div.
module hourly_table_date_interpolator
  import htdi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  req_i,
  output logic      done_o,
  output out_word_t result_o
);
  cmd_t cmd;
  sts_t sts;

  htdi_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i(req_i.req_type),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  htdi_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts),
    .done_o, .result_o
  );
endmodule
